@@ src/dssc_pkg.sv @@
// ----------------------------------------------------------------------------
// dssc_pkg
// Shared types and constants for the diagnostic session startup catcher:
// phase codes, register indexes, transaction payloads and frame constants.
// ----------------------------------------------------------------------------
package dssc_pkg;

  // Default width of the time arithmetic (legal range 32 to 64)
  localparam int unsigned TIME_BITS_DEF = 64;

  // Catcher phases, encoded as reported on the phase output
  typedef enum logic [2:0] {
    PH_DISARMED = 3'd0,
    PH_ARMED    = 3'd1,
    PH_CATCHING = 3'd2,
    PH_CAUGHT   = 3'd3,
    PH_WAIT_OFF = 3'd4
  } phase_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REQUEST_ID    = 3'd0,
    CFG_RESPONSE_ID   = 3'd1,
    CFG_DIAG_BUS      = 3'd2,
    CFG_RETRY_PERIOD  = 3'd3,
    CFG_CATCH_TIMEOUT = 3'd4
  } cfg_reg_e;

  // Input item kinds
  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Request kinds
  localparam logic TX_EXTENDED    = 1'b0;
  localparam logic TX_PROGRAMMING = 1'b1;

  // Register reset values
  localparam logic [10:0] RST_REQUEST_ID    = 11'h7A1;
  localparam logic [10:0] RST_RESPONSE_ID   = 11'h7A9;
  localparam logic [1:0]  RST_DIAG_BUS      = 2'd0;
  localparam logic [31:0] RST_RETRY_PERIOD  = 32'd20_000_000;
  localparam logic [31:0] RST_CATCH_TIMEOUT = 32'd2_000_000_000;

  // Frame payloads, first byte in the most significant byte
  localparam logic [63:0] FRAME_EXTENDED    = 64'h0210_0300_0000_0000;
  localparam logic [63:0] FRAME_PROGRAMMING = 64'h0210_0200_0000_0000;
  localparam logic [63:0] FRAME_POSITIVE    = 64'h0650_0300_3201_F400;
  localparam logic [6:0]  FRAME_LEN_MATCH   = 7'd8;

  // Input transaction payload
  typedef struct packed {
    logic        kind;
    logic [63:0] now_ns;
    logic        arm_enabled;
    logic        health_valid;
    logic        ignition;
    logic [28:0] rx_id;
    logic [1:0]  rx_bus;
    logic [6:0]  rx_length;
    logic [63:0] rx_data;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic        tx_valid;
    logic        tx_kind;
    logic [10:0] tx_id;
    logic [1:0]  tx_bus;
    logic [63:0] tx_data;
    logic        session_start;
    logic        caught;
    logic [2:0]  phase;
    logic        active;
    logic [63:0] ignition_time;
    logic [63:0] first_request_time;
    logic [63:0] response_time;
  } out_item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [10:0] request_id;
    logic [10:0] response_id;
    logic [1:0]  diag_bus;
    logic [31:0] retry_period_ns;
    logic [31:0] catch_timeout_ns;
  } cfg_t;

endpackage

@@ src/dssc_if.sv @@
// ----------------------------------------------------------------------------
// dssc channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface dssc_in_if;
  logic               valid;
  logic               ready;
  dssc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dssc_out_if;
  logic                valid;
  logic                ready;
  dssc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/dssc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dssc_cfg_regs
// Configuration register file; takes one write transaction every cycle.
// ----------------------------------------------------------------------------
module dssc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  dssc_cfg_if.sink       cfg_i,
  output dssc_pkg::cfg_t regs_o
);

  dssc_pkg::cfg_t regs_q;
  dssc_pkg::cfg_t regs_d;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  // Decode the write index; unknown indexes drop the write
  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        dssc_pkg::CFG_REQUEST_ID:    regs_d.request_id       = cfg_i.data[10:0];
        dssc_pkg::CFG_RESPONSE_ID:   regs_d.response_id      = cfg_i.data[10:0];
        dssc_pkg::CFG_DIAG_BUS:      regs_d.diag_bus         = cfg_i.data[1:0];
        dssc_pkg::CFG_RETRY_PERIOD:  regs_d.retry_period_ns  = cfg_i.data;
        dssc_pkg::CFG_CATCH_TIMEOUT: regs_d.catch_timeout_ns = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.request_id       <= dssc_pkg::RST_REQUEST_ID;
      regs_q.response_id      <= dssc_pkg::RST_RESPONSE_ID;
      regs_q.diag_bus         <= dssc_pkg::RST_DIAG_BUS;
      regs_q.retry_period_ns  <= dssc_pkg::RST_RETRY_PERIOD;
      regs_q.catch_timeout_ns <= dssc_pkg::RST_CATCH_TIMEOUT;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

@@ src/dssc_core.sv @@
// ----------------------------------------------------------------------------
// dssc_core
// Catcher state and the single-pass update for one registered item; the
// state advances and the result is valid when step_i is high.
// ----------------------------------------------------------------------------
module dssc_core #(
  parameter int unsigned TIME_BITS = dssc_pkg::TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  dssc_pkg::in_item_t  item_i,
  input  dssc_pkg::cfg_t      cfg_i,
  output dssc_pkg::out_item_t result_o
);

  dssc_pkg::phase_e       phase_q, phase_d;
  logic                   known_q, known_d;
  logic                   last_ign_q, last_ign_d;
  logic [TIME_BITS-1:0]   edge_q, edge_d;
  logic [TIME_BITS-1:0]   first_q, first_d;
  logic [TIME_BITS-1:0]   match_q, match_d;
  logic [TIME_BITS-1:0]   next_q, next_d;

  logic [TIME_BITS-1:0]   now;
  logic [TIME_BITS-1:0]   elapsed;
  logic [TIME_BITS-1:0]   timeout_ext;
  logic [TIME_BITS-1:0]   retry_ext;
  logic                   frame_hit;

  assign now = item_i.now_ns[TIME_BITS-1:0];

  always_comb begin
    timeout_ext        = '0;
    timeout_ext[31:0]  = cfg_i.catch_timeout_ns;
    retry_ext          = '0;
    retry_ext[31:0]    = cfg_i.retry_period_ns;
  end

  // Exact match on the positive session response
  assign frame_hit = (phase_q == dssc_pkg::PH_CATCHING)
                  && (item_i.rx_id == {18'd0, cfg_i.response_id})
                  && (item_i.rx_bus == cfg_i.diag_bus)
                  && (item_i.rx_length == dssc_pkg::FRAME_LEN_MATCH)
                  && (item_i.rx_data == dssc_pkg::FRAME_POSITIVE);

  // Next state and result for the item in the input register
  always_comb begin
    logic tx, tx_prog, start, hit, ign, en;
    tx         = 1'b0;
    tx_prog    = 1'b0;
    start      = 1'b0;
    hit        = 1'b0;
    ign        = item_i.ignition;
    en         = item_i.arm_enabled;
    phase_d    = phase_q;
    known_d    = known_q;
    last_ign_d = last_ign_q;
    edge_d     = edge_q;
    first_d    = first_q;
    match_d    = match_q;
    next_d     = next_q;
    elapsed    = '0;

    if (item_i.kind == dssc_pkg::KIND_POLL) begin
      // Drop out of armed or catching when the enable goes away
      if (!en && (phase_q == dssc_pkg::PH_ARMED || phase_q == dssc_pkg::PH_CATCHING)) begin
        phase_d = (known_q && last_ign_q) ? dssc_pkg::PH_WAIT_OFF : dssc_pkg::PH_DISARMED;
      end

      // Ignition handling
      if (item_i.health_valid) begin
        if (!known_q) begin
          known_d = 1'b1;
          if (ign) begin
            phase_d = dssc_pkg::PH_WAIT_OFF;
          end else begin
            phase_d = en ? dssc_pkg::PH_ARMED : dssc_pkg::PH_DISARMED;
          end
        end else if (ign && !last_ign_q && phase_d == dssc_pkg::PH_ARMED) begin
          edge_d  = now;
          next_d  = now;
          phase_d = dssc_pkg::PH_CATCHING;
          start   = 1'b1;
        end else if (!ign && last_ign_q) begin
          edge_d  = '0;
          first_d = '0;
          match_d = '0;
          next_d  = '0;
          phase_d = en ? dssc_pkg::PH_ARMED : dssc_pkg::PH_DISARMED;
        end else if (!ign && en && phase_d == dssc_pkg::PH_DISARMED) begin
          phase_d = dssc_pkg::PH_ARMED;
        end else if (ign && en && phase_d == dssc_pkg::PH_DISARMED) begin
          phase_d = dssc_pkg::PH_WAIT_OFF;
        end
        last_ign_d = ign;
      end

      // Timeout check, then paced extended requests
      if (phase_d == dssc_pkg::PH_CATCHING) begin
        elapsed = now - edge_d;
        if (elapsed > timeout_ext) begin
          phase_d = dssc_pkg::PH_WAIT_OFF;
        end else if (start || now >= next_d) begin
          tx = 1'b1;
          if (first_d == '0) begin
            first_d = now;
          end
          next_d = now + retry_ext;
        end
      end
    end else begin
      // Positive response: send programming request and hold caught
      if (frame_hit) begin
        tx      = 1'b1;
        tx_prog = 1'b1;
        hit     = 1'b1;
        match_d = now;
        phase_d = dssc_pkg::PH_CAUGHT;
      end
    end

    result_o                    = '0;
    result_o.tx_valid           = tx;
    result_o.tx_kind            = tx_prog ? dssc_pkg::TX_PROGRAMMING : dssc_pkg::TX_EXTENDED;
    result_o.tx_id              = tx ? cfg_i.request_id : 11'd0;
    result_o.tx_bus             = tx ? cfg_i.diag_bus : 2'd0;
    if (tx) begin
      result_o.tx_data = tx_prog ? dssc_pkg::FRAME_PROGRAMMING : dssc_pkg::FRAME_EXTENDED;
    end
    result_o.session_start      = start;
    result_o.caught             = hit;
    result_o.phase              = phase_d;
    result_o.active             = (phase_d == dssc_pkg::PH_CATCHING)
                               || (phase_d == dssc_pkg::PH_CAUGHT);
    result_o.ignition_time[TIME_BITS-1:0]      = edge_d;
    result_o.first_request_time[TIME_BITS-1:0] = first_d;
    result_o.response_time[TIME_BITS-1:0]      = match_d;
  end

  // Commit the state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dssc_pkg::PH_DISARMED;
      known_q    <= 1'b0;
      last_ign_q <= 1'b0;
      edge_q     <= '0;
      first_q    <= '0;
      match_q    <= '0;
      next_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      known_q    <= known_d;
      last_ign_q <= last_ign_d;
      edge_q     <= edge_d;
      first_q    <= first_d;
      match_q    <= match_d;
      next_q     <= next_d;
    end
  end

endmodule

@@ src/diag_session_startup_catcher.sv @@
// ----------------------------------------------------------------------------
// diag_session_startup_catcher
// Arms on ignition off, opens a diagnostic session on the ignition edge,
// repeats extended-session requests and answers a positive response with a
// programming-session request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   dssc_pkg::in_item_t (poll or received frame)
//  out_o    out  valid/ready   dssc_pkg::out_item_t (one per input item)
//  cfg_i    in   valid/ready   3-bit register index, 32-bit write data
//
// Each input transaction passes an input register, combinational update
// logic and a result register; one item per cycle while out_o is not stalled.
// The catcher state commits when the item leaves the input register.
// A stalled result holds the input register; the input side keeps
// accepting as long as that register is free or draining.
// Reset clears the phase, ignition tracking and captured times at once;
// configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module diag_session_startup_catcher #(
  parameter int unsigned TIME_BITS = dssc_pkg::TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dssc_in_if.sink   in_i,
  dssc_out_if.source out_o,
  dssc_cfg_if.sink  cfg_i
);

  dssc_pkg::cfg_t      regs;
  dssc_pkg::in_item_t  item_q;
  logic                item_valid_q;
  dssc_pkg::out_item_t result;
  dssc_pkg::out_item_t result_q;
  logic                result_valid_q, result_valid_d;
  logic                step;

  dssc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // Advance when the result register is free or being drained
  assign step       = item_valid_q && (!result_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || step;

  dssc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (regs),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
  end

  // Result register
  always_comb begin
    result_valid_d = result_valid_q;
    if (step) begin
      result_valid_d = 1'b1;
    end else if (out_o.ready) begin
      result_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_o.valid = result_valid_q;
  assign out_o.data  = result_q;

endmodule
